// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by bpf_div and bond_polynomial_force.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on i_clk, held off while i_rst_n is low
`define ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// check on i_clk at every edge
`define ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("assertion failed");

`endif

// ===== hdl/bpf_pkg.sv =====
// ----------------------------------------------------------------------------
// bpf_pkg
// Types, constants and arithmetic helpers of the bond force pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bpf_pkg;

    localparam int NumBondTypes = 64;
    localparam int TypeW        = 6;
    localparam int NumSlots     = 14;
    localparam int SlotDc1      = 7;
    localparam int SlotR0       = 13;
    localparam int SqSteps      = 32;
    localparam int DivSteps     = 48;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    typedef struct packed {
        logic              action;
        logic [TypeW-1:0]  bond_type;
        logic [3:0]        coeff_slot;
        logic signed [31:0] coeff_value;
        logic signed [31:0] pos1_x;
        logic signed [31:0] pos1_y;
        logic signed [31:0] pos1_z;
        logic signed [31:0] pos2_x;
        logic signed [31:0] pos2_y;
        logic signed [31:0] pos2_z;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] energy;
        logic signed [31:0] virial_xx;
        logic signed [31:0] virial_yy;
        logic signed [31:0] virial_zz;
        logic signed [31:0] virial_xy;
        logic signed [31:0] virial_xz;
        logic signed [31:0] virial_yz;
        logic               zero_distance;
    } t_out_word;

    typedef logic [2:0][31:0]          t_vec;
    typedef logic [NumSlots-1:0][31:0] t_coef;

    typedef struct packed {
        t_vec  d;
        t_coef cf;
    } t_sq_side;

    typedef struct packed {
        t_vec        d;
        logic [31:0] e;
        logic        zero;
    } t_div_side;

    function automatic logic [31:0] sat32(input logic signed [71:0] v);
        if (v > 72'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (v < -72'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [63:0] mul_q(input logic [31:0] a, input logic [31:0] b);
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        wa = $signed({{32{a[31]}}, a});
        wb = $signed({{32{b[31]}}, b});
        return 64'(wa * wb);
    endfunction

    function automatic logic [31:0] floor16_sat(input logic [63:0] p);
        logic signed [71:0] w;
        w = $signed({{8{p[63]}}, p}) >>> 16;
        return sat32(w);
    endfunction

    function automatic logic [31:0] add_sat(input logic [63:0] p, input logic [31:0] c);
        logic signed [71:0] w;
        w = ($signed({{8{p[63]}}, p}) >>> 16) + $signed({{40{c[31]}}, c});
        return sat32(w);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bpf_in_if.sv =====
// ----------------------------------------------------------------------------
// bpf_in_if
// Input channel: valid, ready and one input word.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpf_in_if import bpf_pkg::*; ;
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/bpf_out_if.sv =====
// ----------------------------------------------------------------------------
// bpf_out_if
// Output channel: valid, ready and one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpf_out_if import bpf_pkg::*; ;
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/bpf_sqrt.sv =====
// ----------------------------------------------------------------------------
// bpf_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bpf_sqrt import bpf_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_adv,
    input  wire logic        i_vld,
    input  wire logic [63:0] i_rad,
    input  wire t_sq_side    i_side,
    output logic             o_vld,
    output logic [31:0]      o_root,
    output t_sq_side         o_side
);

    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } t_sqst;

    function automatic t_sqst sq_step(input t_sqst s);
        t_sqst       n;
        logic [35:0] rsh;
        logic [35:0] trial;
        logic [35:0] diff;
        logic        ge;
        rsh   = {s.rem, s.rad[63:62]};
        trial = {2'b00, s.root, 2'b01};
        ge    = (rsh >= trial);
        diff  = rsh - trial;
        n.rem  = ge ? diff[33:0] : rsh[33:0];
        n.root = {s.root[30:0], ge};
        n.rad  = {s.rad[61:0], 2'b00};
        return n;
    endfunction

    t_sqst    r_st   [SqSteps];
    logic     r_vld  [SqSteps];
    t_sq_side r_side [SqSteps];

    t_sqst    w_st   [SqSteps+1];
    logic     w_vld  [SqSteps+1];
    t_sq_side w_side [SqSteps+1];

    assign w_st[0]   = '{rad: i_rad, rem: '0, root: '0};
    assign w_vld[0]  = i_vld;
    assign w_side[0] = i_side;

    for (genvar g = 0; g < SqSteps; g++) begin : g_stage
        assign w_st[g+1]   = r_st[g];
        assign w_vld[g+1]  = r_vld[g];
        assign w_side[g+1] = r_side[g];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_adv) begin
                r_vld[g] <= w_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_st[g]   <= sq_step(w_st[g]);
                r_side[g] <= w_side[g];
            end
        end
    end

    assign o_vld  = w_vld[SqSteps];
    assign o_root = w_st[SqSteps].root;
    assign o_side = w_side[SqSteps];

endmodule

`default_nettype wire

// ===== hdl/bpf_horner.sv =====
// ----------------------------------------------------------------------------
// bpf_horner
// Offset from equilibrium, then energy and derivative polynomials,
// one multiply stage and one add stage per Horner step.
// ----------------------------------------------------------------------------
`default_nettype none

module bpf_horner import bpf_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_adv,
    input  wire logic        i_vld,
    input  wire logic [31:0] i_r,
    input  wire t_sq_side    i_side,
    output logic             o_vld,
    output logic [31:0]      o_dv,
    output logic [31:0]      o_r,
    output t_div_side        o_side
);

    localparam int Steps = 6;

    typedef struct packed {
        logic [31:0] rr0;
        logic [31:0] e;
        logic [31:0] dv;
        logic [63:0] pe;
        logic [63:0] pd;
        logic [31:0] r;
        logic        zero;
        t_vec        d;
        t_coef       cf;
    } t_hst;

    t_hst r_h0;
    logic r_h0_vld;
    t_hst r_m [Steps];
    logic r_m_vld [Steps];
    t_hst r_a [Steps];
    logic r_a_vld [Steps];

    t_hst w_prev [Steps+1];
    logic w_prev_vld [Steps+1];

    t_hst               n_h0;
    logic signed [71:0] w_rr0;

    always_comb begin
        w_rr0   = $signed({40'd0, i_r}) - $signed({{40{i_side.cf[SlotR0][31]}},
                                                    i_side.cf[SlotR0]});
        n_h0      = '0;
        n_h0.rr0  = sat32(w_rr0);
        n_h0.e    = i_side.cf[6];
        n_h0.dv   = i_side.cf[SlotDc1 + 5];
        n_h0.r    = i_r;
        n_h0.zero = (i_r == '0);
        n_h0.d    = i_side.d;
        n_h0.cf   = i_side.cf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h0_vld <= 1'b0;
        end else if (i_adv) begin
            r_h0_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_h0 <= n_h0;
        end
    end

    assign w_prev[0]     = r_h0;
    assign w_prev_vld[0] = r_h0_vld;

    for (genvar s = 0; s < Steps; s++) begin : g_step
        localparam int K = Steps - 1 - s;

        t_hst n_m;
        t_hst n_a;

        assign w_prev[s+1]     = r_a[s];
        assign w_prev_vld[s+1] = r_a_vld[s];

        always_comb begin
            n_m    = w_prev[s];
            n_m.pe = mul_q(w_prev[s].e, w_prev[s].rr0);
            n_m.pd = mul_q(w_prev[s].dv, w_prev[s].rr0);
        end

        always_comb begin
            n_a   = r_m[s];
            n_a.e = add_sat(r_m[s].pe, r_m[s].cf[K]);
            if (K >= 1) begin
                n_a.dv = add_sat(r_m[s].pd, r_m[s].cf[SlotDc1 + K - 1]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_m_vld[s] <= 1'b0;
                r_a_vld[s] <= 1'b0;
            end else if (i_adv) begin
                r_m_vld[s] <= w_prev_vld[s];
                r_a_vld[s] <= r_m_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_m[s] <= n_m;
                r_a[s] <= n_a;
            end
        end
    end

    assign o_vld       = w_prev_vld[Steps];
    assign o_dv        = w_prev[Steps].dv;
    assign o_r         = w_prev[Steps].r;
    assign o_side.d    = w_prev[Steps].d;
    assign o_side.e    = w_prev[Steps].e;
    assign o_side.zero = w_prev[Steps].zero;

endmodule

`default_nettype wire

// ===== hdl/bpf_div.sv =====
// ----------------------------------------------------------------------------
// bpf_div
// Pipelined restoring divider for the force prefactor -D / r,
// one quotient bit per stage, then sign and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bpf_div import bpf_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_adv,
    input  wire logic        i_vld,
    input  wire logic [31:0] i_dv,
    input  wire logic [31:0] i_r,
    input  wire t_div_side   i_side,
    output logic             o_vld,
    output logic [31:0]      o_pre,
    output t_div_side        o_side
);

    typedef struct packed {
        logic [DivSteps-1:0] num;
        logic [31:0]         rem;
        logic [DivSteps-1:0] q;
        logic [31:0]         r;
        logic                neg;
        t_div_side           side;
    } t_dst;

    function automatic t_dst div_step(input t_dst s);
        t_dst        n;
        logic [32:0] rsh;
        logic [32:0] diff;
        logic        ge;
        n     = s;
        rsh   = {s.rem, s.num[DivSteps-1]};
        diff  = rsh - {1'b0, s.r};
        ge    = (rsh >= {1'b0, s.r});
        n.rem = ge ? diff[31:0] : rsh[31:0];
        n.q   = {s.q[DivSteps-2:0], ge};
        n.num = {s.num[DivSteps-2:0], 1'b0};
        return n;
    endfunction

    t_dst r_d0;
    logic r_d0_vld;
    t_dst r_st [DivSteps];
    logic r_vld [DivSteps];

    t_dst w_st [DivSteps+1];
    logic w_vld [DivSteps+1];

    logic [31:0] r_pre;
    logic        r_neg;
    logic        r_out_vld;
    t_div_side   r_side;

    t_dst        n_d0;
    logic [31:0] w_mag;
    logic [31:0] n_pre;
    t_dst        w_last;

    always_comb begin
        w_mag     = i_dv[31] ? (32'd0 - i_dv) : i_dv;
        n_d0.num  = {w_mag, 16'd0};
        n_d0.rem  = '0;
        n_d0.q    = '0;
        n_d0.r    = i_r;
        n_d0.neg  = !i_dv[31] && (i_dv != '0);
        n_d0.side = i_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0_vld <= 1'b0;
        end else if (i_adv) begin
            r_d0_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d0 <= n_d0;
        end
    end

    assign w_st[0]  = r_d0;
    assign w_vld[0] = r_d0_vld;

    for (genvar g = 0; g < DivSteps; g++) begin : g_stage
        assign w_st[g+1]  = r_st[g];
        assign w_vld[g+1] = r_vld[g];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_adv) begin
                r_vld[g] <= w_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_st[g] <= div_step(w_st[g]);
            end
        end
    end

    assign w_last = w_st[DivSteps];

    always_comb begin
        if (w_last.neg) begin
            if (w_last.q > DivSteps'(33'h0_8000_0000)) begin
                n_pre = 32'h8000_0000;
            end else begin
                n_pre = 32'd0 - w_last.q[31:0];
            end
        end else begin
            if (w_last.q > DivSteps'(32'h7fff_ffff)) begin
                n_pre = 32'h7fff_ffff;
            end else begin
                n_pre = w_last.q[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_adv) begin
            r_out_vld <= w_vld[DivSteps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pre  <= n_pre;
            r_neg  <= w_last.neg;
            r_side <= w_last.side;
        end
    end

    assign o_vld  = r_out_vld;
    assign o_pre  = r_pre;
    assign o_side = r_side;

    `ASSERT_RST(a_pre_sign, r_out_vld && r_neg |-> $signed(r_pre) <= 0)

endmodule

`default_nettype wire

// ===== hdl/bpf_back.sv =====
// ----------------------------------------------------------------------------
// bpf_back
// Force from the prefactor, virial products with periodicity gating,
// and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpf_back import bpf_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_adv,
    input  wire logic        i_vld,
    input  wire logic [31:0] i_pre,
    input  wire t_div_side   i_side,
    input  wire logic [1:0]  i_pdims,
    output logic             o_vld,
    output t_out_word        o_word
);

    logic             r_f1_vld;
    logic [2:0][63:0] r_f1_p;
    t_div_side        r_f1_side;

    logic             r_f2_vld;
    t_vec             r_f2_f;
    t_div_side        r_f2_side;

    logic             r_f3_vld;
    logic [5:0][63:0] r_f3_p;
    t_vec             r_f3_f;
    t_div_side        r_f3_side;

    logic             r_out_vld;
    t_out_word        r_out;

    t_vec             n_f2_f;
    logic [5:0][63:0] n_f3_p;
    t_out_word        n_out;
    logic             w_en_diag;
    logic             w_en_off;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_f2_f[i] = r_f1_side.zero ? 32'd0 : floor16_sat(r_f1_p[i]);
        end
    end

    always_comb begin
        n_f3_p[0] = mul_q(r_f2_side.d[0], r_f2_f[0]);
        n_f3_p[1] = mul_q(r_f2_side.d[1], r_f2_f[1]);
        n_f3_p[2] = mul_q(r_f2_side.d[2], r_f2_f[2]);
        n_f3_p[3] = mul_q(r_f2_side.d[0], r_f2_f[1]);
        n_f3_p[4] = mul_q(r_f2_side.d[0], r_f2_f[2]);
        n_f3_p[5] = mul_q(r_f2_side.d[1], r_f2_f[2]);
    end

    assign w_en_diag = i_pdims[1];
    assign w_en_off  = (i_pdims == 2'd3);

    always_comb begin
        n_out.force_x       = r_f3_f[0];
        n_out.force_y       = r_f3_f[1];
        n_out.force_z       = r_f3_f[2];
        n_out.energy        = r_f3_side.e;
        n_out.virial_xx     = w_en_diag ? floor16_sat(r_f3_p[0]) : 32'd0;
        n_out.virial_yy     = w_en_diag ? floor16_sat(r_f3_p[1]) : 32'd0;
        n_out.virial_zz     = w_en_diag ? floor16_sat(r_f3_p[2]) : 32'd0;
        n_out.virial_xy     = w_en_diag ? floor16_sat(r_f3_p[3]) : 32'd0;
        n_out.virial_xz     = w_en_off  ? floor16_sat(r_f3_p[4]) : 32'd0;
        n_out.virial_yz     = w_en_off  ? floor16_sat(r_f3_p[5]) : 32'd0;
        n_out.zero_distance = r_f3_side.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld  <= 1'b0;
            r_f2_vld  <= 1'b0;
            r_f3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (i_adv) begin
            r_f1_vld  <= i_vld;
            r_f2_vld  <= r_f1_vld;
            r_f3_vld  <= r_f2_vld;
            r_out_vld <= r_f3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_f1_p[i] <= mul_q(i_side.d[i], i_pre);
            end
            r_f1_side <= i_side;
            r_f2_f    <= n_f2_f;
            r_f2_side <= r_f1_side;
            r_f3_p    <= n_f3_p;
            r_f3_f    <= r_f2_f;
            r_f3_side <= r_f2_side;
            r_out     <= n_out;
        end
    end

    assign o_vld  = r_out_vld;
    assign o_word = r_out;

endmodule

`default_nettype wire

// ===== hdl/bond_polynomial_force.sv =====
// ----------------------------------------------------------------------------
// bond_polynomial_force
// Force, energy and virial of a polynomial two-atom bond, fully pipelined.
// ----------------------------------------------------------------------------
// One word enters per cycle unless the output word waits, loads and bonds alike; a
// bond word passes the one-bit-per-stage square root (32 stages), the Horner
// multiply/add stages and the divider (48 stages) before its result leaves.
// Load words write the per-type coefficient memory at acceptance and make no
// result; a bond word reads its coefficients at acceptance, so it sees every
// load taken before it. The whole pipeline holds while the output word waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bond_polynomial_force import bpf_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    bpf_in_if.sink          i_in,
    bpf_out_if.source       o_out,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_wdata
);

    logic [31:0] r_mem [NumSlots][NumBondTypes];

    logic [1:0]  r_pdims;
    logic        w_adv;
    logic        w_acc;

    logic        r_s1_vld;
    t_vec        r_s1_d;
    t_coef       r_s1_cf;
    logic        r_s2_vld;
    logic [2:0][63:0] r_s2_sq;
    t_sq_side    r_s2_side;
    logic        r_s3_vld;
    logic [63:0] r_s3_r2;
    t_sq_side    r_s3_side;

    t_vec        n_s1_d;

    logic        w_sq_vld;
    logic [31:0] w_root;
    t_sq_side    w_sq_side;
    logic        w_h_vld;
    logic [31:0] w_h_dv;
    logic [31:0] w_h_r;
    t_div_side   w_h_side;
    logic        w_d_vld;
    logic [31:0] w_pre;
    t_div_side   w_d_side;
    logic        w_o_vld;
    t_out_word   w_o_word;

    assign w_adv      = !w_o_vld || o_out.ready;
    assign w_acc      = i_in.valid && w_adv;
    assign i_in.ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pdims <= 2'd3;
        end else if (i_cfg_we) begin
            r_pdims <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && i_in.data.action == ACT_LOAD && i_in.data.coeff_slot < 4'(NumSlots)) begin
            r_mem[i_in.data.coeff_slot][i_in.data.bond_type] <= i_in.data.coeff_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < NumSlots; k++) begin
                r_s1_cf[k] <= r_mem[k][i_in.data.bond_type];
            end
        end
    end

    always_comb begin
        n_s1_d[0] = sat32(72'(i_in.data.pos1_x) - 72'(i_in.data.pos2_x));
        n_s1_d[1] = sat32(72'(i_in.data.pos1_y) - 72'(i_in.data.pos2_y));
        n_s1_d[2] = sat32(72'(i_in.data.pos1_z) - 72'(i_in.data.pos2_z));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= w_acc && i_in.data.action == ACT_COMPUTE;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_d       <= n_s1_d;
            for (int i = 0; i < 3; i++) begin
                r_s2_sq[i] <= mul_q(r_s1_d[i], r_s1_d[i]);
            end
            r_s2_side.d  <= r_s1_d;
            r_s2_side.cf <= r_s1_cf;
            r_s3_r2      <= r_s2_sq[0] + r_s2_sq[1] + r_s2_sq[2];
            r_s3_side    <= r_s2_side;
        end
    end

    bpf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (r_s3_vld),
        .i_rad   (r_s3_r2),
        .i_side  (r_s3_side),
        .o_vld   (w_sq_vld),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    bpf_horner u_horner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (w_sq_vld),
        .i_r     (w_root),
        .i_side  (w_sq_side),
        .o_vld   (w_h_vld),
        .o_dv    (w_h_dv),
        .o_r     (w_h_r),
        .o_side  (w_h_side)
    );

    bpf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (w_h_vld),
        .i_dv    (w_h_dv),
        .i_r     (w_h_r),
        .i_side  (w_h_side),
        .o_vld   (w_d_vld),
        .o_pre   (w_pre),
        .o_side  (w_d_side)
    );

    bpf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (w_d_vld),
        .i_pre   (w_pre),
        .i_side  (w_d_side),
        .i_pdims (r_pdims),
        .o_vld   (w_o_vld),
        .o_word  (w_o_word)
    );

    assign o_out.valid = w_o_vld;
    assign o_out.data  = w_o_word;

    `ASSERT_RST(a_zero_force, o_out.valid && o_out.data.zero_distance |-> o_out.data.force_x == 0 && o_out.data.force_y == 0 && o_out.data.force_z == 0)
    `ASSERT_RST(a_zero_virial, o_out.valid && o_out.data.zero_distance |-> o_out.data.virial_xx == 0 && o_out.data.virial_xy == 0 && o_out.data.virial_yz == 0)
    `ASSERT_RST(a_stall_hold, o_out.valid && !o_out.ready |=> $stable(r_s3_r2) && $stable(r_s1_d))

endmodule

`default_nettype wire
